### hdl/sapp_pkg.sv
// ----------------------------------------------------------------------------
// sapp_pkg
// Shared widths and default sizes for the sub-pixel antialiased pixel plot.
// ----------------------------------------------------------------------------
`default_nettype none

package sapp_pkg;

    // Default frame matrix size.
    localparam int DEF_MATRIX_COLS = 16;
    localparam int DEF_MATRIX_ROWS = 16;

    // Field widths fixed by the interface.
    localparam int POS_W  = 4;
    localparam int CHAN_W = 8;
    localparam int IDX_W  = 8;
    localparam int PIX_W  = 3 * CHAN_W;

    // Width that holds a corner column or row and any matrix dimension.
    localparam int DIM_W = 9;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

endpackage

`default_nettype wire

### hdl/subpixel_antialiased_pixel_plot.sv
// Steps: a corner inside the matrix goes through the weight, red, green and blue steps
// and a write step; one outside it goes straight from the weight step to the write step.
// A new plot is accepted only in the idle state, once all four corners of the last one
// are written; the write step holds while the result side stalls.
// One shared 8x8 multiplier and one single-port frame memory serve the plot steps.
// Reset: the memory is cleared one pixel a cycle over all MATRIX_COLS*MATRIX_ROWS pixels first.
// ----------------------------------------------------------------------------
// subpixel_antialiased_pixel_plot
// Plots one color at a sub-pixel position into an RGB frame memory, spreading
// it over the four neighboring pixels with saturating adds.
// ----------------------------------------------------------------------------
`default_nettype none

module subpixel_antialiased_pixel_plot
    import sapp_pkg::*;
#(
    parameter int MATRIX_COLS = DEF_MATRIX_COLS,
    parameter int MATRIX_ROWS = DEF_MATRIX_ROWS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [POS_W-1:0]  col_whole,
    input  wire logic [CHAN_W-1:0] col_frac,
    input  wire logic [POS_W-1:0]  row_whole,
    input  wire logic [CHAN_W-1:0] row_frac,
    input  wire logic [CHAN_W-1:0] red_in,
    input  wire logic [CHAN_W-1:0] green_in,
    input  wire logic [CHAN_W-1:0] blue_in,

    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [IDX_W-1:0]       pixel_index,
    output logic [CHAN_W-1:0]      red_out,
    output logic [CHAN_W-1:0]      green_out,
    output logic [CHAN_W-1:0]      blue_out,
    output logic                   in_range,
    output logic                   last_corner
);

    localparam int DEPTH = MATRIX_COLS * MATRIX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (AW > IDX_W) ? AW : IDX_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WEIGHT,
        ST_MUL_R,
        ST_MUL_G,
        ST_MUL_B,
        ST_WRITE
    } state_t;

    state_t              state_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic [1:0]          corner_reg;

    logic [POS_W-1:0]    col_reg;
    logic [CHAN_W-1:0]   xx_reg;
    logic [POS_W-1:0]    row_reg;
    logic [CHAN_W-1:0]   yy_reg;
    logic [CHAN_W-1:0]   red_reg;
    logic [CHAN_W-1:0]   green_reg;
    logic [CHAN_W-1:0]   blue_reg;
    logic [CHAN_W-1:0]   weight_reg;
    logic [CHAN_W-1:0]   red_pix_reg;
    logic [CHAN_W-1:0]   green_pix_reg;
    logic [CHAN_W-1:0]   blue_pix_reg;

    logic                out_valid_reg;
    logic [IDX_W-1:0]    pixel_index_reg;
    logic [CHAN_W-1:0]   red_out_reg;
    logic [CHAN_W-1:0]   green_out_reg;
    logic [CHAN_W-1:0]   blue_out_reg;
    logic                in_range_reg;
    logic                last_corner_reg;

    logic [PIX_W-1:0]    frame_mem [DEPTH];
    logic [PIX_W-1:0]    mem_rdata_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_addr;
    logic [PIX_W-1:0]    mem_wdata;

    logic [DIM_W-1:0]    corner_col;
    logic [DIM_W-1:0]    corner_row;
    logic                corner_ok;
    logic [XW-1:0]       corner_addr;

    logic [CHAN_W-1:0]   mul_a;
    logic [CHAN_W-1:0]   mul_b;
    logic [2*CHAN_W-1:0] mul_p;
    logic [2*CHAN_W:0]   weight_sum;
    logic [CHAN_W-1:0]   pix_chan;
    logic [CHAN_W:0]     chan_sum;
    logic [CHAN_W-1:0]   chan_sat;
    logic                load_out;

    // Corner order: bit 0 of the corner steps the column, bit 1 the row.
    always_comb
    begin
        corner_col  = DIM_W'(col_reg) + DIM_W'(corner_reg[0]);
        corner_row  = DIM_W'(row_reg) + DIM_W'(corner_reg[1]);
        corner_ok   = (corner_col < DIM_W'(MATRIX_COLS)) &&
                      (corner_row < DIM_W'(MATRIX_ROWS));
        corner_addr = XW'(corner_row) * XW'(MATRIX_COLS) + XW'(corner_col);
    end

    // Shared multiplier: corner weight in the weight step, channel scaling after.
    always_comb
    begin
        mul_a    = red_reg;
        mul_b    = weight_reg;
        pix_chan = mem_rdata_reg[3*CHAN_W-1:2*CHAN_W];
        case (state_reg)
            ST_WEIGHT:
            begin
                mul_a = corner_reg[0] ? xx_reg : (CHAN_MAX - xx_reg);
                mul_b = corner_reg[1] ? yy_reg : (CHAN_MAX - yy_reg);
            end
            ST_MUL_G:
            begin
                mul_a    = green_reg;
                pix_chan = mem_rdata_reg[2*CHAN_W-1:CHAN_W];
            end
            ST_MUL_B:
            begin
                mul_a    = blue_reg;
                pix_chan = mem_rdata_reg[CHAN_W-1:0];
            end
            default:
            begin
                mul_a = red_reg;
            end
        endcase
        mul_p      = mul_a * mul_b;
        weight_sum = (2*CHAN_W+1)'(mul_p) + (2*CHAN_W+1)'(mul_a) +
                     (2*CHAN_W+1)'(mul_b);
        chan_sum   = (CHAN_W+1)'(pix_chan) + (CHAN_W+1)'(mul_p[2*CHAN_W-1:CHAN_W]);
        chan_sat   = chan_sum[CHAN_W] ? CHAN_MAX : chan_sum[CHAN_W-1:0];
    end

    assign load_out = (state_reg == ST_WRITE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = corner_addr[AW-1:0];
        mem_wdata = {red_pix_reg, green_pix_reg, blue_pix_reg};
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_addr  = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (load_out && corner_ok)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= frame_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            corner_reg      <= '0;
            out_valid_reg   <= 1'b0;
            in_range_reg    <= 1'b0;
            last_corner_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        col_reg    <= col_whole;
                        xx_reg     <= col_frac;
                        row_reg    <= row_whole;
                        yy_reg     <= row_frac;
                        red_reg    <= red_in;
                        green_reg  <= green_in;
                        blue_reg   <= blue_in;
                        corner_reg <= '0;
                        state_reg  <= ST_WEIGHT;
                    end
                end
                ST_WEIGHT:
                begin
                    weight_reg <= weight_sum[2*CHAN_W-1:CHAN_W];
                    state_reg  <= corner_ok ? ST_MUL_R : ST_WRITE;
                end
                ST_MUL_R:
                begin
                    red_pix_reg <= chan_sat;
                    state_reg   <= ST_MUL_G;
                end
                ST_MUL_G:
                begin
                    green_pix_reg <= chan_sat;
                    state_reg     <= ST_MUL_B;
                end
                ST_MUL_B:
                begin
                    blue_pix_reg <= chan_sat;
                    state_reg    <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    if (load_out)
                    begin
                        out_valid_reg   <= 1'b1;
                        in_range_reg    <= corner_ok;
                        last_corner_reg <= (corner_reg == 2'd3);
                        pixel_index_reg <= corner_ok ? corner_addr[IDX_W-1:0] : '0;
                        red_out_reg     <= corner_ok ? red_pix_reg : '0;
                        green_out_reg   <= corner_ok ? green_pix_reg : '0;
                        blue_out_reg    <= corner_ok ? blue_pix_reg : '0;
                        corner_reg      <= corner_reg + 1'b1;
                        state_reg       <= (corner_reg == 2'd3) ? ST_IDLE : ST_WEIGHT;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign red_out     = red_out_reg;
    assign green_out   = green_out_reg;
    assign blue_out    = blue_out_reg;
    assign in_range    = in_range_reg;
    assign last_corner = last_corner_reg;

    // A skipped corner carries an all-zero pixel and address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !in_range_reg) |->
            (pixel_index_reg == '0 && red_out_reg == '0 &&
             green_out_reg == '0 && blue_out_reg == '0))
        else $error("skipped corner result is not zero");

    // The memory is written only by the clearing pass or a corner update.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_WRITE))
        else $error("frame memory written outside clear or update");

    // Finishing the fourth corner flags it and frees the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && corner_reg == 2'd3) |=> (last_corner_reg && in_ready))
        else $error("fourth corner did not end the plot");

    // A new plot always starts on the first corner.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (corner_reg == 2'd0))
        else $error("corner counter not at zero while idle");

endmodule

`default_nettype wire
